>>> hw/rtl/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg: shared types and microcode for the text terminal writer
// Screen geometry, character codes, the control word layout and the
// read-only microprogram stepped by tts_seq.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int COLS      = 64;
    localparam int ROWS      = 16;
    localparam int CELLS     = COLS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = $clog2(COLS);
    localparam int CHAR_W    = 7;
    localparam int LAST_DEST = CELLS - COLS - 1;   // last cell written by the row copy
    localparam int BOT_ROW   = CELLS - COLS;       // first cell of the bottom row

    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_FF    = 8'h0C;
    localparam logic [7:0] CODE_LEFT  = 8'h0F;
    localparam logic [7:0] CODE_ERASE = 8'h7F;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_TILDE = 8'h7E;

    // microprogram entries
    typedef enum logic [3:0] {
        U_IDLE, U_CLR, U_RD0, U_RD1, U_DONE, U_LF, U_CR, U_LEFT,
        U_ERASE, U_PUT, U_PUTW, U_FF, U_PRIME, U_COPY, U_TAIL, U_FILL
    } t_upc;

    typedef enum logic [1:0] {K_ALWAYS, K_ADDR_LAST, K_COPY_LAST, K_OUT_FREE} t_cond;
    typedef enum logic [1:0] {A_HOLD, A_INC, A_BOT} t_aop;
    typedef enum logic {R_ITEM, R_SRC} t_rsel;
    typedef enum logic [1:0] {W_ZERO, W_SPACE, W_CHAR, W_RDATA} t_wsel;
    typedef enum logic [1:0] {WA_ADDR, WA_CURSOR, WA_PREV} t_wasel;
    typedef enum logic [2:0] {CU_HOLD, CU_LF, CU_CR, CU_LEFT, CU_HOME, CU_ADV} t_cop;

    typedef struct packed {
        logic   ready;      // waiting for an item
        logic   we;
        t_wsel  wsel;
        t_wasel wasel;
        t_rsel  rsel;
        t_aop   aop;
        t_cop   cop;
        logic   cell_load;
        logic   out_load;
        t_cond  cond;
        t_upc   loop_pc;    // taken while cond is false
        t_upc   next_pc;    // taken once cond is true
    } t_uword;

    typedef struct packed {
        logic accept;
        t_upc entry;
        logic addr_last;
        logic copy_last;
        logic out_free;
    } t_seq_stat;

    function automatic t_uword ucode(t_upc pc);
        t_uword w;
        w         = '0;
        w.cond    = K_ALWAYS;
        w.loop_pc = pc;
        w.next_pc = U_DONE;
        case (pc)
            U_IDLE: begin
                w.ready   = 1'b1;
                w.next_pc = U_IDLE;
            end
            U_CLR: begin
                w.we = 1'b1; w.wsel = W_ZERO; w.wasel = WA_ADDR; w.aop = A_INC;
                w.cond = K_ADDR_LAST; w.next_pc = U_IDLE;
            end
            U_RD0: begin
                w.rsel = R_ITEM; w.next_pc = U_RD1;
            end
            U_RD1: w.cell_load = 1'b1;
            U_DONE: begin
                w.out_load = 1'b1; w.cond = K_OUT_FREE; w.next_pc = U_IDLE;
            end
            U_LF:   w.cop = CU_LF;
            U_CR:   w.cop = CU_CR;
            U_LEFT: w.cop = CU_LEFT;
            U_ERASE: begin
                w.we = 1'b1; w.wsel = W_SPACE; w.wasel = WA_CURSOR;
            end
            U_PUT: begin
                w.we = 1'b1; w.wsel = W_CHAR; w.wasel = WA_CURSOR; w.cop = CU_ADV;
            end
            U_PUTW: begin
                w.we = 1'b1; w.wsel = W_CHAR; w.wasel = WA_CURSOR; w.cop = CU_ADV;
                w.next_pc = U_PRIME;
            end
            U_FF: begin
                w.cop = CU_HOME; w.next_pc = U_FILL;
            end
            U_PRIME: begin
                w.rsel = R_SRC; w.aop = A_INC; w.next_pc = U_COPY;
            end
            U_COPY: begin
                w.rsel = R_SRC; w.we = 1'b1; w.wsel = W_RDATA; w.wasel = WA_PREV;
                w.aop = A_INC; w.cond = K_COPY_LAST; w.next_pc = U_TAIL;
            end
            U_TAIL: begin
                w.we = 1'b1; w.wsel = W_RDATA; w.wasel = WA_PREV; w.aop = A_BOT;
                w.next_pc = U_FILL;
            end
            U_FILL: begin
                w.we = 1'b1; w.wsel = W_SPACE; w.wasel = WA_ADDR; w.aop = A_INC;
                w.cond = K_ADDR_LAST;
            end
            default: w.next_pc = U_IDLE;
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/text_terminal_cursor_scroll_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_top: glass-teletype text writer
// 64x16 character store with a write cursor, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser = op (0 put code, 1 read cell), tdata holds the
//   character code and the cell address. Each transaction yields exactly one
//   output transaction carrying the cursor position and, for reads, the cell.
//   One item is worked at a time; the input is ready only while the
//   sequencer sits at its idle step.
//   A line feed on the bottom row and a character in the last cell scroll
//   the store; form feed homes the cursor and blanks every cell. These go
//   through the single write port of the text store: a scroll copies one
//   cell per cycle, then blanks the new bottom row one cell per cycle.
//   The result sits in an output register; the sequencer waits on its last
//   step while the receiver stalls with the register full, and goes on as
//   soon as the register is free.
//   Reset: cursor to 0, then a clearing pass writes zero to every cell; no
//   item is accepted during it.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] char_code, [17:8] cell_addr, rest zero
    input  logic        i_s_axis_tuser,   // [0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // [9:0] cursor_pos, [16:10] cell_data, rest zero
);
    import tts_pkg::*;

    t_uword    w_uw;
    t_seq_stat w_stat;

    logic [CHAR_W-1:0] r_mem [CELLS];
    logic [CHAR_W-1:0] r_rdata;

    logic [AW-1:0]     r_cursor, n_cursor;
    logic [CW-1:0]     r_col, n_col;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_prev;
    logic [7:0]        r_code;
    logic [9:0]        r_item_addr;
    logic [CHAR_W-1:0] r_cell;
    logic              r_out_valid;
    logic [9:0]        r_out_cursor;
    logic [CHAR_W-1:0] r_out_cell;

    logic              w_accept;
    logic              w_out_fire;
    logic [7:0]        w_code;
    logic [AW-1:0]     w_raddr;
    logic [AW-1:0]     w_waddr;
    logic [CHAR_W-1:0] w_wdata;
    logic              w_in_range;
    t_upc              w_entry;

    tts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uw    (w_uw)
    );

    assign o_s_axis_tready = w_uw.ready;
    assign w_accept        = i_s_axis_tvalid && w_uw.ready;
    assign w_code          = i_s_axis_tdata[7:0];
    assign w_out_fire      = w_uw.out_load && w_stat.out_free;

    // dispatch: choose the routine for an incoming item
    always_comb begin
        if (i_s_axis_tuser) begin
            w_entry = U_RD0;
        end else begin
            case (w_code)
                CODE_LF:    w_entry = (32'(r_cursor) >= 32'(BOT_ROW)) ? U_PRIME : U_LF;
                CODE_CR:    w_entry = U_CR;
                CODE_FF:    w_entry = U_FF;
                CODE_LEFT:  w_entry = U_LEFT;
                CODE_ERASE: w_entry = U_ERASE;
                default: begin
                    if (w_code inside {[CODE_SPACE:CODE_TILDE]}) begin
                        w_entry = (r_cursor == AW'(CELLS - 1)) ? U_PUTW : U_PUT;
                    end else begin
                        w_entry = U_DONE;
                    end
                end
            endcase
        end
    end

    assign w_stat.accept    = w_accept;
    assign w_stat.entry     = w_entry;
    assign w_stat.addr_last = (r_addr == AW'(CELLS - 1));
    assign w_stat.copy_last = (r_addr == AW'(LAST_DEST));
    assign w_stat.out_free  = !r_out_valid || i_m_axis_tready;

    assign w_raddr    = (w_uw.rsel == R_SRC) ? AW'(r_addr + AW'(COLS)) : AW'(r_item_addr);
    assign w_in_range = (32'(r_item_addr) < 32'(CELLS));

    always_comb begin
        case (w_uw.wasel)
            WA_ADDR:   w_waddr = r_addr;
            WA_CURSOR: w_waddr = r_cursor;
            WA_PREV:   w_waddr = r_prev;
            default:   w_waddr = r_addr;
        endcase
        case (w_uw.wsel)
            W_ZERO:  w_wdata = '0;
            W_SPACE: w_wdata = CODE_SPACE[CHAR_W-1:0];
            W_CHAR:  w_wdata = r_code[CHAR_W-1:0];
            W_RDATA: w_wdata = r_rdata;
            default: w_wdata = '0;
        endcase
    end

    // cursor unit; the column rides along so carriage return needs no divide
    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        case (w_uw.cop)
            CU_LF: n_cursor = AW'(r_cursor + AW'(COLS));
            CU_CR: begin
                n_cursor = AW'(r_cursor - AW'(r_col));
                n_col    = '0;
            end
            CU_LEFT: begin
                if (r_cursor != '0) begin
                    n_cursor = AW'(r_cursor - 1'b1);
                    n_col    = (r_col == '0) ? CW'(COLS - 1) : CW'(r_col - 1'b1);
                end
            end
            CU_HOME: begin
                n_cursor = '0;
                n_col    = '0;
            end
            CU_ADV: begin
                if (r_cursor == AW'(CELLS - 1)) begin
                    n_cursor = AW'(BOT_ROW);
                    n_col    = '0;
                end else begin
                    n_cursor = AW'(r_cursor + 1'b1);
                    n_col    = (r_col == CW'(COLS - 1)) ? '0 : CW'(r_col + 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        case (w_uw.aop)
            A_INC:   n_addr = AW'(r_addr + 1'b1);
            A_BOT:   n_addr = AW'(BOT_ROW);
            default: n_addr = r_addr;
        endcase
        if (w_accept) begin
            n_addr = '0;
        end
    end

    // text store
    always_ff @(posedge i_clk) begin
        if (w_uw.we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_col       <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_addr   <= n_addr;
            if (w_out_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= r_addr;
        if (w_accept) begin
            r_code      <= w_code;
            r_item_addr <= i_s_axis_tdata[17:8];
            r_cell      <= '0;
        end else if (w_uw.cell_load) begin
            r_cell <= w_in_range ? r_rdata : '0;
        end
        if (w_out_fire) begin
            r_out_cursor <= 10'(r_cursor);
            r_out_cell   <= r_cell;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_cell, r_out_cursor};

    a_cursor_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cursor) < 32'(CELLS))
        else $error("cursor left the store");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_uw.we)
        else $error("store written while waiting for an item");

    a_cursor_still_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_axis_tready && !i_s_axis_tvalid) |=> $stable(r_cursor))
        else $error("cursor moved with no item in progress");

    a_result_presented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire |=> (o_m_axis_tvalid && o_s_axis_tready))
        else $error("result load did not present output and return to idle");

endmodule

>>> hw/rtl/tts_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_seq: microprogram sequencer
// Step counter over the control store; dispatches on an accepted item and
// loops on a step until its condition holds.
// ----------------------------------------------------------------------------
module tts_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tts_pkg::t_seq_stat i_stat,
    output tts_pkg::t_uword    o_uw
);
    import tts_pkg::*;

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword w_uw;
    logic   w_cond_ok;

    assign w_uw = ucode(r_pc);
    assign o_uw = w_uw;

    always_comb begin
        case (w_uw.cond)
            K_ALWAYS:    w_cond_ok = 1'b1;
            K_ADDR_LAST: w_cond_ok = i_stat.addr_last;
            K_COPY_LAST: w_cond_ok = i_stat.copy_last;
            K_OUT_FREE:  w_cond_ok = i_stat.out_free;
            default:     w_cond_ok = 1'b1;
        endcase
        if (w_uw.ready) begin
            n_pc = i_stat.accept ? i_stat.entry : U_IDLE;
        end else begin
            n_pc = w_cond_ok ? w_uw.next_pc : w_uw.loop_pc;
        end
    end

    // reset starts the store clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_CLR;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: text_terminal_cursor_scroll_top regression
// Drives put and read transactions into the text terminal writer and keeps a
// shadow copy of the cursor and the 64x16 character store. Each output
// transaction is checked field by field against the oldest pending
// prediction. Directed edge cases come first: cursor-left at home, erase,
// ignored codes, form feed, a character in the last cell and a line feed on
// the bottom row. A random mix of text lines, cursor moves, noise and reads
// follows, under bursty input and a stalling output.
// ----------------------------------------------------------------------------
import tts_pkg::*;

typedef enum bit {OP_PUT = 1'b0, OP_READ = 1'b1} t_term_op;

typedef struct packed {
    logic [9:0] cursor_pos;
    logic [6:0] cell_data;
} t_term_result;

class terminal_scoreboard;
    int unsigned  cursor;
    bit [6:0]     screen [CELLS];
    t_term_result due_results [$];
    int           n_puts, n_reads, n_ignored, n_scrolls, n_clears, n_checked, n_errors;

    function new();
        cursor = 0;
        foreach (screen[i]) screen[i] = '0;
    endfunction

    function void scroll_up();
        for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = 7'(CODE_SPACE);
        n_scrolls++;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    // advance the shadow state by one accepted transaction
    function void note_item(t_term_op op, logic [7:0] code, logic [9:0] addr);
        t_term_result r;
        r.cell_data = '0;
        if (op == OP_PUT) begin
            n_puts++;
            if (cursor >= CELLS) cursor = 0;
            case (code)
                CODE_LF: begin
                    if (cursor >= BOT_ROW) scroll_up();
                    else cursor += COLS;
                end
                CODE_CR: cursor -= cursor % COLS;
                CODE_FF: begin
                    cursor = 0;
                    foreach (screen[i]) screen[i] = 7'(CODE_SPACE);
                    n_clears++;
                end
                CODE_LEFT: begin
                    if (cursor != 0) cursor--;
                end
                CODE_ERASE: screen[cursor] = 7'(CODE_SPACE);
                default: begin
                    if (code inside {[CODE_SPACE:CODE_TILDE]}) begin
                        screen[cursor] = code[6:0];
                        cursor++;
                        if (cursor >= CELLS) begin
                            cursor -= COLS;
                            scroll_up();
                        end
                    end else begin
                        n_ignored++;
                    end
                end
            endcase
        end else begin
            n_reads++;
            if (addr < CELLS) r.cell_data = screen[addr];
        end
        r.cursor_pos = cursor[9:0];
        due_results.push_back(r);
    endfunction

    function void check_result(logic [23:0] word);
        t_term_result want;
        if (due_results.size() == 0) begin
            $error("unexpected transaction: cursor_pos %0d, cell_data 0x%02h",
                   word[9:0], word[16:10]);
            n_errors++;
            return;
        end
        want = due_results.pop_front();
        n_checked++;
        if (word[9:0] !== want.cursor_pos) begin
            $error("cursor_pos mismatch: expected %0d, actual %0d",
                   want.cursor_pos, word[9:0]);
            n_errors++;
        end
        if (word[16:10] !== want.cell_data) begin
            $error("cell_data mismatch: expected 0x%02h, actual 0x%02h",
                   want.cell_data, word[16:10]);
            n_errors++;
        end
    endfunction
endclass

module testbench;

    localparam int TOTAL_ITEMS  = 580;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int LONG_HOLD    = 1500;
    localparam int HOLD_AT      = 250;
    localparam int PAUSE_AT     = 420;
    localparam int DRAIN_CYCLES = CELLS + 16;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} t_rx_mode;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [7:0] char_code, [17:8] cell_addr
    logic        s_tuser  = 1'b0; // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [9:0] cursor_pos, [16:10] cell_data

    terminal_scoreboard sb;
    int unsigned        cycle_count = 0;
    int                 items_sent  = 0;
    int                 burst_left  = 0;
    bit                 hold_req    = 1'b0;

    text_terminal_cursor_scroll_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    initial begin
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("text_terminal_cursor_scroll_top regression: fail");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // output backpressure: spans of differing stall density, one long hold-off
    initial begin
        t_rx_mode mode;
        int       span;
        int       phase;
        phase = 0;
        wait (rst_n);
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            repeat (span) begin
                @(negedge clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                end
                phase++;
                case (mode)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
                    default:  m_tready <= ((phase % 7) < 4);
                endcase
            end
        end
    end

    // input side works in bursts; a burst may start with no gap at all
    task automatic send_item(t_term_op op, logic [7:0] code, logic [9:0] addr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, addr, code};
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, code, addr);
        items_sent++;
    endtask

    task automatic put(logic [7:0] code);
        send_item(OP_PUT, code, 10'($urandom));
    endtask

    task automatic read_cell(logic [9:0] addr);
        send_item(OP_READ, 8'($urandom), addr);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_printable();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return CODE_SPACE;
        if (pick == 1) return CODE_TILDE;
        return 8'($urandom_range(33, 125));
    endfunction

    function automatic logic [7:0] rand_ignored();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0) return 8'h80 | 8'($urandom);
        do c = 8'($urandom_range(0, 31));
        while (c == CODE_LF || c == CODE_CR || c == CODE_FF || c == CODE_LEFT);
        return c;
    endfunction

    // half the reads land near the cursor, where the text is changing
    task automatic read_random();
        int unsigned row_base;
        row_base = (sb.cursor / COLS) * COLS;
        case ($urandom_range(0, 3))
            0: read_cell(10'(row_base + $urandom_range(0, COLS - 1)));
            1: read_cell(10'((row_base >= COLS ? row_base - COLS : row_base)
                             + $urandom_range(0, COLS - 1)));
            default: read_cell(10'($urandom));
        endcase
    endtask

    // a line of text, usually closed by CR LF
    task automatic type_line();
        int n;
        n = $urandom_range(1, 24);
        repeat (n) put(rand_printable());
        if ($urandom_range(0, 5) != 0) put(CODE_CR);
        if ($urandom_range(0, 5) != 0) put(CODE_LF);
        if ($urandom_range(0, 2) == 0) read_random();
    endtask

    // column 0, step back onto column 63 of the row above, line-feed down to
    // the last cell, then one character so the cursor runs off the end
    task automatic run_to_last_cell();
        if (sb.cursor % COLS != 0) put(CODE_CR);
        if (sb.cursor < COLS) put(CODE_LF);
        put(CODE_LEFT);
        while (sb.cursor < BOT_ROW) put(CODE_LF);
        put(rand_printable());
    endtask

    initial begin
        int pick;
        bit hold_asked;
        bit paused;
        hold_asked = 1'b0;
        paused     = 1'b0;
        wait (rst_n);

        put(CODE_LEFT);            // cursor-left at home stays put
        put(CODE_TILDE);
        put(CODE_SPACE);
        put(CODE_ERASE);           // blank a cell never written
        read_cell(10'd2);
        put(8'hFF);
        put(CODE_FF);
        run_to_last_cell();
        put(CODE_LF);              // line feed on the bottom row
        read_cell(10'(CELLS - 1));

        while (items_sent < TOTAL_ITEMS) begin
            if (!hold_asked && items_sent >= HOLD_AT) begin
                hold_asked = 1'b1;
                hold_req   = 1'b1;
            end
            if (!paused && items_sent >= PAUSE_AT) begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                read_random();
            end else if (pick < 72) begin
                type_line();
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 4)) put(CODE_LEFT);
                put(CODE_ERASE);
            end else if (pick < 91) begin
                put(8'($urandom));
            end else if (pick < 95) begin
                put(rand_ignored());
            end else if (pick < 98) begin
                run_to_last_cell();
            end else begin
                put(CODE_FF);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0) begin
            $error("%0d predicted transactions never arrived", sb.pending());
            sb.n_errors++;
        end
        $display("covered %0d puts (%0d ignored codes) and %0d reads",
                 sb.n_puts, sb.n_ignored, sb.n_reads);
        $display("%0d scrolls, %0d screen clears, %0d results checked, %0d errors",
                 sb.n_scrolls, sb.n_clears, sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("text_terminal_cursor_scroll_top regression: pass");
        end else begin
            $display("text_terminal_cursor_scroll_top regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tts_pkg.sv
hw/rtl/tts_seq.sv
hw/rtl/text_terminal_cursor_scroll_top.sv
verif/testbench.sv
